// ----- hw/rtl/qcpw_pkg.sv -----
// Shared types, register codes and divider step functions for the quad corner point warp.
// Used by every module under hw/rtl; no dependencies of its own.
package qcpw_pkg;

    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 24;

    localparam int FracQW           = 18;
    localparam int FracRemW         = 15;
    localparam int FracStepsPerStage = 3;
    localparam int FracStages       = FracQW / FracStepsPerStage;

    localparam int TQW            = 42;
    localparam int TRemW          = 49;
    localparam int TStepsPerStage = 2;
    localparam int TStages        = TQW / TStepsPerStage;

    typedef logic signed [15:0] t_point;
    typedef logic        [14:0] t_size;
    typedef logic        [23:0] t_corner;
    typedef logic        [11:0] t_coord;
    typedef logic signed [17:0] t_frac;
    typedef logic signed [23:0] t_q8;
    typedef logic signed [47:0] t_prod;
    typedef logic signed [48:0] t_cross;
    typedef logic signed [41:0] t_tval;

    localparam t_frac FracMax = {1'b0, {17{1'b1}}};
    localparam t_frac FracMin = {1'b1, 17'd0};
    localparam logic [FracQW:0] FracNegLim = 19'd131072;
    localparam logic [TQW:0]    TLimMag    = 43'h100_0000_0000;
    localparam t_q8 OutMax = {1'b0, {23{1'b1}}};
    localparam t_q8 OutMin = {1'b1, 23'd0};

    typedef enum logic [CfgIdxW-1:0] {
        CfgBoundX   = 4'd0,
        CfgBoundY   = 4'd1,
        CfgBoundW   = 4'd2,
        CfgBoundH   = 4'd3,
        CfgCornerUl = 4'd4,
        CfgCornerUr = 4'd5,
        CfgCornerBl = 4'd6,
        CfgCornerBr = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic zero;
    } t_div_ctl;

    typedef struct packed {
        t_q8 lx;
        t_q8 ly;
        t_q8 ax;
        t_q8 ay;
    } t_line;

    typedef struct packed {
        t_q8  mapped_x;
        t_q8  mapped_y;
        logic ok;
        logic sat;
    } t_result;

    function automatic t_coord corner_x(input t_corner c);
        return c[11:0];
    endfunction

    function automatic t_coord corner_y(input t_corner c);
        return c[23:12];
    endfunction

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [FracRemW:0] frac_step(input logic [FracRemW-1:0] rem,
                                                    input logic din, input t_size d);
        logic [FracRemW:0] s;
        logic [FracRemW:0] res;
        s = {rem, din};
        if (s >= {1'b0, d}) begin
            res = {1'b1, FracRemW'(s - {1'b0, d})};
        end else begin
            res = {1'b0, s[FracRemW-1:0]};
        end
        return res;
    endfunction

    function automatic logic [TRemW:0] t_step(input logic [TRemW-1:0] rem,
                                              input logic din, input logic [TRemW-1:0] d);
        logic [TRemW:0] s;
        logic [TRemW:0] res;
        s = {rem, din};
        if (s >= {1'b0, d}) begin
            res = {1'b1, TRemW'(s - {1'b0, d})};
        end else begin
            res = {1'b0, s[TRemW-1:0]};
        end
        return res;
    endfunction

    // {clamped flag, Q16.8 value}
    function automatic logic [24:0] clamp_q8(input logic signed [50:0] v);
        logic [24:0] res;
        if (v > 51'(OutMax)) begin
            res = {1'b1, OutMax};
        end else if (v < 51'(OutMin)) begin
            res = {1'b1, OutMin};
        end else begin
            res = {1'b0, v[23:0]};
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/quad_corner_point_warp.sv -----
// Top level of the quad corner point warp: register file, pipeline and output skid stage.
// Depends on qcpw_pkg and the qcpw_* submodules.
//
// Maps a source point (Q12.4) into the quadrilateral set by four corner registers and
// returns the warped point in Q16.8 with parallel-line and clamp flags.
// Input channel: i_valid / o_stall with i_point_x, i_point_y; a transfer happens on an
// edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_mapped_x, o_mapped_y, o_mapping_ok, o_saturated.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; o_cfg_ready
// is always high. Write registers only while no point is in flight.
// Throughput: one point per cycle while o_stall is low. The two pipelined dividers
// (fraction, 6 stages; line parameter, 21 stages) make up most of the pipeline.
// Reset (synchronous, active low) loads the register defaults and empties the pipeline.
// When the receiver stalls, the output register holds and one more result lands in a
// skid register; while that is full, o_stall is high and the whole pipeline holds.
module quad_corner_point_warp import qcpw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_point              i_point_x,
    input  t_point              i_point_y,
    output logic                o_valid,
    input  logic                i_stall,
    output t_q8                 o_mapped_x,
    output t_q8                 o_mapped_y,
    output logic                o_mapping_ok,
    output logic                o_saturated,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    t_point  bound_x, bound_y;
    t_size   bound_w, bound_h;
    t_corner ul, ur, bl, br;

    logic    en;
    logic    dx_v, dy_v, geom_v, tdiv_v, pipe_v;
    t_frac   dx, dy;
    t_cross  den, num;
    t_line   geom_line, tdiv_line;
    t_tval   tval;
    logic    tdiv_zero;
    t_result pipe_res;

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;

    assign o_cfg_ready = 1'b1;
    assign en          = !r_skid_v;
    assign o_stall     = r_skid_v;

    qcpw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bound_x   (bound_x),
        .o_bound_y   (bound_y),
        .o_bound_w   (bound_w),
        .o_bound_h   (bound_h),
        .o_ul        (ul),
        .o_ur        (ur),
        .o_bl        (bl),
        .o_br        (br)
    );

    qcpw_frac_div u_frac_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_point  (i_point_x),
        .i_origin (bound_x),
        .i_size   (bound_w),
        .o_valid  (dx_v),
        .o_frac   (dx)
    );

    qcpw_frac_div u_frac_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_point  (i_point_y),
        .i_origin (bound_y),
        .i_size   (bound_h),
        .o_valid  (dy_v),
        .o_frac   (dy)
    );

    qcpw_edge_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dx_v),
        .i_dx    (dx),
        .i_dy    (dy),
        .i_ul    (ul),
        .i_ur    (ur),
        .i_bl    (bl),
        .i_br    (br),
        .o_valid (geom_v),
        .o_den   (den),
        .o_num   (num),
        .o_line  (geom_line)
    );

    qcpw_t_div u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (geom_v),
        .i_den   (den),
        .i_num   (num),
        .i_line  (geom_line),
        .o_valid (tdiv_v),
        .o_t     (tval),
        .o_zero  (tdiv_zero),
        .o_line  (tdiv_line)
    );

    qcpw_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (tdiv_v),
        .i_t     (tval),
        .i_zero  (tdiv_zero),
        .i_line  (tdiv_line),
        .o_valid (pipe_v),
        .o_res   (pipe_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_skid_v) begin
            if (pipe_v) begin
                if (!r_out_v || !i_stall) begin
                    r_out_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end else if (!i_stall) begin
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v) begin
            if (pipe_v && (!r_out_v || !i_stall)) begin
                r_out <= pipe_res;
            end
            if (pipe_v && r_out_v && i_stall) begin
                r_skid <= pipe_res;
            end
        end else if (!i_stall) begin
            r_out <= r_skid;
        end
    end

    assign o_valid      = r_out_v;
    assign o_mapped_x   = r_out.mapped_x;
    assign o_mapped_y   = r_out.mapped_y;
    assign o_mapping_ok = r_out.ok;
    assign o_saturated  = r_out.sat;

    ap_skid_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register full while output register empty");

    ap_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_stall) |=> (!r_skid_v && r_out_v))
        else $error("skid register did not drain on output transfer");

    ap_axes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dx_v == dy_v)
        else $error("fraction lanes out of step");

    ap_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.ok) |-> (r_out.mapped_x == '0 && r_out.mapped_y == '0
                                    && !r_out.sat))
        else $error("parallel-line result not cleared");

endmodule

// ----- hw/rtl/qcpw_cfg_regs.sv -----
// Configuration register file: bounding box and the four target corners.
// Depends on qcpw_pkg for the register codes and field types.
module qcpw_cfg_regs import qcpw_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_point              o_bound_x,
    output t_point              o_bound_y,
    output t_size               o_bound_w,
    output t_size               o_bound_h,
    output t_corner             o_ul,
    output t_corner             o_ur,
    output t_corner             o_bl,
    output t_corner             o_br
);

    t_point  r_bound_x, r_bound_y;
    t_size   r_bound_w, r_bound_h;
    t_corner r_ul, r_ur, r_bl, r_br;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_x <= '0;
            r_bound_y <= '0;
            r_bound_w <= 15'd16384;
            r_bound_h <= 15'd1600;
            r_ul      <= 24'd1048832;
            r_ur      <= 24'd1049344;
            r_bl      <= 24'd3145984;
            r_br      <= 24'd3146496;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgBoundX:   r_bound_x <= i_cfg_data[15:0];
                CfgBoundY:   r_bound_y <= i_cfg_data[15:0];
                CfgBoundW:   r_bound_w <= i_cfg_data[14:0];
                CfgBoundH:   r_bound_h <= i_cfg_data[14:0];
                CfgCornerUl: r_ul      <= i_cfg_data;
                CfgCornerUr: r_ur      <= i_cfg_data;
                CfgCornerBl: r_bl      <= i_cfg_data;
                CfgCornerBr: r_br      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_bound_x = r_bound_x;
    assign o_bound_y = r_bound_y;
    assign o_bound_w = r_bound_w;
    assign o_bound_h = r_bound_h;
    assign o_ul      = r_ul;
    assign o_ur      = r_ur;
    assign o_bl      = r_bl;
    assign o_br      = r_br;

endmodule

// ----- hw/rtl/qcpw_frac_div.sv -----
// Pipelined restoring divider giving a clamped Q2.16 box fraction, floor rounded.
// Depends on qcpw_pkg; one instance per axis.
module qcpw_frac_div import qcpw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_point i_point,
    input  t_point i_origin,
    input  t_size  i_size,
    output logic   o_valid,
    output t_frac  o_frac
);

    logic [FracStages+1:0] r_v;
    logic [FracRemW-1:0]   r_rem [0:FracStages];
    logic [FracQW-1:0]     r_q   [0:FracStages];
    logic [FracQW-1:0]     r_lo  [0:FracStages];
    t_div_ctl              r_ctl [0:FracStages];
    t_frac                 r_frac;

    logic [FracRemW-1:0] n_rem [0:FracStages];
    logic [FracQW-1:0]   n_q   [0:FracStages];
    logic [FracQW-1:0]   n_lo  [0:FracStages];
    t_div_ctl            n_ctl0;
    t_frac               n_frac;

    always_comb begin
        logic signed [16:0] diff;
        logic        [16:0] mag;
        diff = 17'(i_point) - 17'(i_origin);
        mag  = diff[16] ? 17'(-diff) : 17'(diff);
        n_ctl0.neg  = diff[16];
        n_ctl0.ovf  = mag >= {i_size, 2'b00};
        n_ctl0.zero = (i_size == '0);
        n_rem[0] = mag[16:2];
        n_q[0]   = '0;
        n_lo[0]  = {mag[1:0], 16'd0};
    end

    always_comb begin
        logic [FracRemW-1:0] rem;
        logic [FracQW-1:0]   q;
        logic [FracQW-1:0]   lo;
        logic [FracRemW:0]   st;
        for (int k = 1; k <= FracStages; k++) begin
            rem = r_rem[k-1];
            q   = r_q[k-1];
            lo  = r_lo[k-1];
            for (int j = 0; j < FracStepsPerStage; j++) begin
                st  = frac_step(rem, lo[FracQW-1], i_size);
                rem = st[FracRemW-1:0];
                q   = {q[FracQW-2:0], st[FracRemW]};
                lo  = {lo[FracQW-2:0], 1'b0};
            end
            n_rem[k] = rem;
            n_q[k]   = q;
            n_lo[k]  = lo;
        end
    end

    always_comb begin
        logic [FracQW-1:0] q;
        logic [FracQW:0]   up;
        t_div_ctl          ctl;
        q   = r_q[FracStages];
        ctl = r_ctl[FracStages];
        up  = {1'b0, q} + (FracQW+1)'(|r_rem[FracStages]);
        if (ctl.zero) begin
            n_frac = '0;
        end else if (!ctl.neg) begin
            n_frac = (ctl.ovf || q[FracQW-1]) ? FracMax : t_frac'(q);
        end else begin
            n_frac = (ctl.ovf || up > FracNegLim) ? FracMin : t_frac'((FracQW+1)'(0) - up);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[FracStages:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0] <= n_ctl0;
            for (int k = 0; k <= FracStages; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_lo[k]  <= n_lo[k];
            end
            for (int k = 1; k <= FracStages; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r_frac <= n_frac;
        end
    end

    assign o_valid = r_v[FracStages+1];
    assign o_frac  = r_frac;

endmodule

// ----- hw/rtl/qcpw_edge_geom.sv -----
// Edge interpolation and line setup: T, B, L, R points, then the cross products den and num.
// Depends on qcpw_pkg; five register stages.
module qcpw_edge_geom import qcpw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_frac   i_dx,
    input  t_frac   i_dy,
    input  t_corner i_ul,
    input  t_corner i_ur,
    input  t_corner i_bl,
    input  t_corner i_br,
    output logic    o_valid,
    output t_cross  o_den,
    output t_cross  o_num,
    output t_line   o_line
);

    // edge order: Tx Ty Bx By Lx Ly Rx Ry
    t_coord             c0 [8];
    t_coord             c1 [8];
    t_frac              f  [8];
    logic signed [12:0] n_span [8];

    logic [4:0]         r_v;
    logic signed [30:0] r_prod [8];
    t_q8                r_pt   [8];
    t_q8                r_ax, r_ay, r_gx, r_gy, r_hx, r_hy, r_lx, r_ly;
    t_prod              r_p    [4];
    t_line              r_line_d, r_line_e;
    t_cross             r_den, r_num;

    always_comb begin
        c0[0] = corner_x(i_ul); c1[0] = corner_x(i_ur); f[0] = i_dx;
        c0[1] = corner_y(i_ul); c1[1] = corner_y(i_ur); f[1] = i_dx;
        c0[2] = corner_x(i_bl); c1[2] = corner_x(i_br); f[2] = i_dx;
        c0[3] = corner_y(i_bl); c1[3] = corner_y(i_br); f[3] = i_dx;
        c0[4] = corner_x(i_ul); c1[4] = corner_x(i_bl); f[4] = i_dy;
        c0[5] = corner_y(i_ul); c1[5] = corner_y(i_bl); f[5] = i_dy;
        c0[6] = corner_x(i_ur); c1[6] = corner_x(i_br); f[6] = i_dy;
        c0[7] = corner_y(i_ur); c1[7] = corner_y(i_br); f[7] = i_dy;
        for (int e = 0; e < 8; e++) begin
            n_span[e] = $signed({1'b0, c1[e]}) - $signed({1'b0, c0[e]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [31:0] sum;
        if (i_en) begin
            for (int e = 0; e < 8; e++) begin
                r_prod[e] <= n_span[e] * f[e];
                sum        = $signed({4'd0, c0[e], 16'd0}) + 32'(r_prod[e]);
                r_pt[e]   <= sum[31:8];
            end
            r_ax <= r_pt[6] - r_pt[4];
            r_ay <= r_pt[7] - r_pt[5];
            r_gx <= r_pt[0] - r_pt[2];
            r_gy <= r_pt[1] - r_pt[3];
            r_hx <= r_pt[4] - r_pt[0];
            r_hy <= r_pt[5] - r_pt[1];
            r_lx <= r_pt[4];
            r_ly <= r_pt[5];

            r_p[0] <= r_ay * r_gx;
            r_p[1] <= r_ax * r_gy;
            r_p[2] <= r_gy * r_hx;
            r_p[3] <= r_gx * r_hy;
            r_line_d <= '{lx: r_lx, ly: r_ly, ax: r_ax, ay: r_ay};

            r_den    <= 49'(r_p[0]) - 49'(r_p[1]);
            r_num    <= 49'(r_p[2]) - 49'(r_p[3]);
            r_line_e <= r_line_d;
        end
    end

    assign o_valid = r_v[4];
    assign o_den   = r_den;
    assign o_num   = r_num;
    assign o_line  = r_line_e;

endmodule

// ----- hw/rtl/qcpw_t_div.sv -----
// Pipelined restoring divider for the line parameter t = floor(num*65536/den), clamped to 2^40.
// Depends on qcpw_pkg; two quotient bits per stage.
module qcpw_t_div import qcpw_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_cross i_den,
    input  t_cross i_num,
    input  t_line  i_line,
    output logic   o_valid,
    output t_tval  o_t,
    output logic   o_zero,
    output t_line  o_line
);

    logic [TStages+1:0] r_v;
    logic [TRemW-1:0]   r_rem  [0:TStages];
    logic [TRemW-1:0]   r_d    [0:TStages];
    logic [TQW-1:0]     r_q    [0:TStages];
    logic [TQW-1:0]     r_lo   [0:TStages];
    t_div_ctl           r_ctl  [0:TStages];
    t_line              r_line [0:TStages];
    t_tval              r_t;
    logic               r_zero;
    t_line              r_line_out;

    logic [TRemW-1:0] n_rem [0:TStages];
    logic [TQW-1:0]   n_q   [0:TStages];
    logic [TQW-1:0]   n_lo  [0:TStages];
    logic [TRemW-1:0] n_d0;
    t_div_ctl         n_ctl0;
    t_tval            n_t;

    always_comb begin
        logic [TRemW-1:0] mag_n;
        mag_n = i_num[TRemW-1] ? TRemW'(-i_num) : TRemW'(i_num);
        n_d0  = i_den[TRemW-1] ? TRemW'(-i_den) : TRemW'(i_den);
        n_ctl0.neg  = i_num[TRemW-1] ^ i_den[TRemW-1];
        n_ctl0.ovf  = {26'd0, mag_n} >= {n_d0, 26'd0};
        n_ctl0.zero = (i_den == '0);
        n_rem[0] = TRemW'(mag_n[TRemW-1:26]);
        n_q[0]   = '0;
        n_lo[0]  = {mag_n[25:0], 16'd0};
    end

    always_comb begin
        logic [TRemW-1:0] rem;
        logic [TQW-1:0]   q;
        logic [TQW-1:0]   lo;
        logic [TRemW:0]   st;
        for (int k = 1; k <= TStages; k++) begin
            rem = r_rem[k-1];
            q   = r_q[k-1];
            lo  = r_lo[k-1];
            for (int j = 0; j < TStepsPerStage; j++) begin
                st  = t_step(rem, lo[TQW-1], r_d[k-1]);
                rem = st[TRemW-1:0];
                q   = {q[TQW-2:0], st[TRemW]};
                lo  = {lo[TQW-2:0], 1'b0};
            end
            n_rem[k] = rem;
            n_q[k]   = q;
            n_lo[k]  = lo;
        end
    end

    always_comb begin
        logic [TQW:0] up;
        t_div_ctl     ctl;
        ctl = r_ctl[TStages];
        up  = {1'b0, r_q[TStages]} + (TQW+1)'(|r_rem[TStages]);
        if (!ctl.neg) begin
            n_t = (ctl.ovf || {1'b0, r_q[TStages]} > TLimMag) ? t_tval'(TLimMag)
                                                               : t_tval'(r_q[TStages]);
        end else begin
            n_t = (ctl.ovf || up > TLimMag) ? t_tval'((TQW+1)'(0) - TLimMag)
                                            : t_tval'((TQW+1)'(0) - up);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[TStages:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0]  <= n_ctl0;
            r_d[0]    <= n_d0;
            r_line[0] <= i_line;
            for (int k = 0; k <= TStages; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_lo[k]  <= n_lo[k];
            end
            for (int k = 1; k <= TStages; k++) begin
                r_ctl[k]  <= r_ctl[k-1];
                r_d[k]    <= r_d[k-1];
                r_line[k] <= r_line[k-1];
            end
            r_t        <= n_t;
            r_zero     <= r_ctl[TStages].zero;
            r_line_out <= r_line[TStages];
        end
    end

    assign o_valid = r_v[TStages+1];
    assign o_t     = r_t;
    assign o_zero  = r_zero;
    assign o_line  = r_line_out;

endmodule

// ----- hw/rtl/qcpw_finish.sv -----
// Result stage: L + a*t/65536 per axis with the product cut in two halves, then clamp to Q16.8.
// Depends on qcpw_pkg; three register stages.
module qcpw_finish import qcpw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_tval   i_t,
    input  logic    i_zero,
    input  t_line   i_line,
    output logic    o_valid,
    output t_result o_res
);

    logic [2:0]         r_v;
    logic signed [44:0] r_hx, r_hy;
    logic signed [45:0] r_lx_p, r_ly_p;
    logic signed [65:0] r_sx, r_sy;
    t_q8                r_l0x, r_l0y, r_l1x, r_l1y;
    logic               r_z0, r_z1;
    t_result            r_res;

    logic signed [20:0] th;
    logic signed [21:0] tl;
    t_result            n_res;

    assign th = i_t[41:21];
    assign tl = $signed({1'b0, i_t[20:0]});

    always_comb begin
        logic [24:0]        cx;
        logic [24:0]        cy;
        logic signed [50:0] vx;
        logic signed [50:0] vy;
        vx = 51'(r_l1x) + 51'(r_sx >>> 16);
        vy = 51'(r_l1y) + 51'(r_sy >>> 16);
        cx = clamp_q8(vx);
        cy = clamp_q8(vy);
        if (r_z1) begin
            n_res = '0;
        end else begin
            n_res.mapped_x = cx[23:0];
            n_res.mapped_y = cy[23:0];
            n_res.ok       = 1'b1;
            n_res.sat      = cx[24] | cy[24];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hx   <= i_line.ax * th;
            r_hy   <= i_line.ay * th;
            r_lx_p <= i_line.ax * tl;
            r_ly_p <= i_line.ay * tl;
            r_l0x  <= i_line.lx;
            r_l0y  <= i_line.ly;
            r_z0   <= i_zero;

            r_sx  <= (66'(r_hx) <<< 21) + 66'(r_lx_p);
            r_sy  <= (66'(r_hy) <<< 21) + 66'(r_ly_p);
            r_l1x <= r_l0x;
            r_l1y <= r_l0y;
            r_z1  <= r_z0;

            r_res <= n_res;
        end
    end

    assign o_valid = r_v[2];
    assign o_res   = r_res;

endmodule
